FILE: hdl/prd_pkg.sv
// Package for the pixel ray direction core: register indexes, widths and shared types.
// No dependencies.
package prd_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 48;

    localparam logic [CFG_IDX_BITS-1:0] REG_FORWARD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ASPECT  = 3'd5;

    localparam logic [47:0] FORWARD_RST = 48'hC000_0000_0000;
    localparam logic [47:0] RIGHT_RST   = 48'h0000_0000_4000;
    localparam logic [47:0] UP_RST      = 48'h0000_4000_0000;
    localparam logic [12:0] WIDTH_RST   = 13'd640;
    localparam logic [12:0] HEIGHT_RST  = 13'd480;
    localparam logic [15:0] ASPECT_RST  = 16'd5461;

    // Normalized magnitudes lie in [2^29, 2^30)
    localparam int NORM_BITS = 30;
    localparam int SUMSQ_BITS = 62;
    localparam int LEN_BITS = 31;

    // Square-root cell payload; the running root is kept aligned with the bit
    // under test, so it needs the full remainder width in the early cells
    typedef struct packed {
        logic                    vld;
        logic [SUMSQ_BITS-1:0]   rem;
        logic [SUMSQ_BITS:0]     root;
        logic [NORM_BITS-1:0]    ax;
        logic [NORM_BITS-1:0]    ay;
        logic [NORM_BITS-1:0]    az;
        logic [2:0]              neg;
        logic                    zero;
    } sqrt_tok_t;

    // Divider cell payload, three lanes share one divisor
    typedef struct packed {
        logic                    vld;
        logic [LEN_BITS-1:0]     den;
        logic [NORM_BITS+15:0]   rx;
        logic [NORM_BITS+15:0]   ry;
        logic [NORM_BITS+15:0]   rz;
        logic [15:0]             qx;
        logic [15:0]             qy;
        logic [15:0]             qz;
        logic [2:0]              neg;
        logic                    zero;
    } div_tok_t;

endpackage

FILE: hdl/prd_sqrt_cell.sv
// One root-bit step of the digit-by-digit integer square root, registered.
// Depends on prd_pkg.
module prd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  prd_pkg::sqrt_tok_t tok_in,
    output prd_pkg::sqrt_tok_t tok_out
);

    localparam int BITPOS = prd_pkg::SUMSQ_BITS - 2 - 2 * STEP;

    prd_pkg::sqrt_tok_t tok_reg;
    prd_pkg::sqrt_tok_t tok_next;
    logic [prd_pkg::SUMSQ_BITS:0] trial;
    logic [prd_pkg::SUMSQ_BITS:0] bitv;

    // Trial subtract of root + bit
    always_comb begin
        tok_next = tok_in;
        bitv = '0;
        bitv[BITPOS] = 1'b1;
        trial = {1'b0, tok_in.rem} - (tok_in.root + bitv);
        if (!trial[prd_pkg::SUMSQ_BITS]) begin
            tok_next.rem = trial[prd_pkg::SUMSQ_BITS-1:0];
            tok_next.root = (tok_in.root >> 1) + bitv;
        end else begin
            tok_next.root = tok_in.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else if (en) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hdl/prd_div_cell.sv
// One restoring-division bit step for three lanes sharing a divisor.
// Depends on prd_pkg.
module prd_div_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  prd_pkg::div_tok_t tok_in,
    output prd_pkg::div_tok_t tok_out
);

    prd_pkg::div_tok_t tok_reg;
    prd_pkg::div_tok_t tok_next;
    logic [prd_pkg::NORM_BITS+16:0] dx, dy, dz;
    logic [prd_pkg::NORM_BITS+16:0] dd;

    // Shift the next dividend bit (top of q) into the remainder, compare to
    // divisor, take a quotient bit into the bottom of q
    always_comb begin
        tok_next = tok_in;
        dd = {{16{1'b0}}, tok_in.den};
        dx = {tok_in.rx, tok_in.qx[15]} - dd;
        dy = {tok_in.ry, tok_in.qy[15]} - dd;
        dz = {tok_in.rz, tok_in.qz[15]} - dd;
        tok_next.rx = dx[prd_pkg::NORM_BITS+16]
                      ? {tok_in.rx[prd_pkg::NORM_BITS+14:0], tok_in.qx[15]}
                      : dx[prd_pkg::NORM_BITS+15:0];
        tok_next.ry = dy[prd_pkg::NORM_BITS+16]
                      ? {tok_in.ry[prd_pkg::NORM_BITS+14:0], tok_in.qy[15]}
                      : dy[prd_pkg::NORM_BITS+15:0];
        tok_next.rz = dz[prd_pkg::NORM_BITS+16]
                      ? {tok_in.rz[prd_pkg::NORM_BITS+14:0], tok_in.qz[15]}
                      : dz[prd_pkg::NORM_BITS+15:0];
        tok_next.qx = {tok_in.qx[14:0], ~dx[prd_pkg::NORM_BITS+16]};
        tok_next.qy = {tok_in.qy[14:0], ~dy[prd_pkg::NORM_BITS+16]};
        tok_next.qz = {tok_in.qz[14:0], ~dz[prd_pkg::NORM_BITS+16]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else if (en) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hdl/pixel_ray_direction_core.sv
// Pixel ray direction core: pinhole camera primary ray generation.
// One request per cycle while the pipeline is not stalled.
// Most of the pipeline is the chains of screen divider, square-root and divider cells.
// Whole pipeline stalls when the output register is full and not taken.
// Reset (aresetn low, synchronous) clears valid bits and loads camera defaults.
// Depends on prd_pkg, prd_sqrt_cell, prd_div_cell.
module pixel_ray_direction_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [COORD_BITS-1:0] s_column,
    input  logic [COORD_BITS-1:0] s_row,
    input  logic [7:0]           s_sub_x,
    input  logic [7:0]           s_sub_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_dir_x,
    output logic signed [15:0]   m_dir_y,
    output logic signed [15:0]   m_dir_z,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [prd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [prd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int RB = COORD_BITS + 8;      // raster width
    localparam int NB = RB + 2;              // screen numerator magnitude
    localparam int DB = 21;                  // 256*W width
    localparam int SDW = NB + FRAC_BITS + 1; // scaled numerator
    localparam int QW = 48;                  // screen quotient width
    localparam int SCR_STEPS = SDW;
    localparam int VB = 16 + QW + 2;         // component sum width
    localparam int MB = VB - 1;
    localparam int SQ_STEPS = prd_pkg::SUMSQ_BITS / 2;
    localparam int DV_STEPS = 16;
    localparam int NORM_STEPS = 7;           // log2 of MB rounded up

    // ---------------- configuration registers
    logic [47:0] fwd_reg, rgt_reg, up_reg;
    logic [12:0] wid_reg, hgt_reg;
    logic [15:0] asp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= prd_pkg::FORWARD_RST;
            rgt_reg <= prd_pkg::RIGHT_RST;
            up_reg  <= prd_pkg::UP_RST;
            wid_reg <= prd_pkg::WIDTH_RST;
            hgt_reg <= prd_pkg::HEIGHT_RST;
            asp_reg <= prd_pkg::ASPECT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                prd_pkg::REG_FORWARD: fwd_reg <= cfg_data;
                prd_pkg::REG_RIGHT:   rgt_reg <= cfg_data;
                prd_pkg::REG_UP:      up_reg  <= cfg_data;
                prd_pkg::REG_WIDTH:   wid_reg <= cfg_data[12:0];
                prd_pkg::REG_HEIGHT:  hgt_reg <= cfg_data[12:0];
                prd_pkg::REG_ASPECT:  asp_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- global stall: advance when output slot is free
    logic en;
    logic out_vld_reg;
    assign en = !out_vld_reg || m_ready;
    assign s_ready = en;

    // ---------------- stage 0: numerators
    logic [12:0] w_eff, h_eff;
    logic [RB-1:0] rx, ry;
    logic signed [NB:0] numx, numy;
    assign w_eff = (wid_reg == 13'd0) ? 13'd1 : wid_reg;
    assign h_eff = (hgt_reg == 13'd0) ? 13'd1 : hgt_reg;
    assign rx = {s_column, s_sub_x};
    assign ry = {s_row, s_sub_y};
    assign numx = $signed({2'b00, rx, 1'b0}) - $signed({{(NB-DB+1){1'b0}}, w_eff, 8'd0});
    assign numy = $signed({{(NB-DB+1){1'b0}}, h_eff, 8'd0}) - $signed({2'b00, ry, 1'b0});

    // Screen divider cells: chain of restoring steps, x and y in parallel.
    // The dividend magnitude*2^F + den/2 is shifted in bit by bit; the remainder starts at zero.
    logic              sv_reg [SCR_STEPS+1];
    logic [SDW-1:0]    snx_reg [SCR_STEPS+1], sny_reg [SCR_STEPS+1];
    logic [DB:0]       srx_reg [SCR_STEPS+1], sry_reg [SCR_STEPS+1];
    logic [SDW-1:0]    sqx_reg [SCR_STEPS+1], sqy_reg [SCR_STEPS+1];
    logic [DB-1:0]     sdx_reg [SCR_STEPS+1], sdy_reg [SCR_STEPS+1];
    logic              ssx_reg [SCR_STEPS+1], ssy_reg [SCR_STEPS+1];

    logic [NB:0] magx, magy;
    assign magx = numx[NB] ? (NB+1)'(0) - numx : numx;
    assign magy = numy[NB] ? (NB+1)'(0) - numy : numy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg[0] <= 1'b0;
        end else if (en) begin
            sv_reg[0] <= s_valid;
        end
        if (en) begin
            snx_reg[0] <= SDW'({magx, {FRAC_BITS{1'b0}}}) + SDW'({w_eff, 7'd0});
            sny_reg[0] <= SDW'({magy, {FRAC_BITS{1'b0}}}) + SDW'({h_eff, 7'd0});
            sdx_reg[0] <= {w_eff, 8'd0};
            sdy_reg[0] <= {h_eff, 8'd0};
            srx_reg[0] <= '0;
            sry_reg[0] <= '0;
            sqx_reg[0] <= '0;
            sqy_reg[0] <= '0;
            ssx_reg[0] <= numx[NB];
            ssy_reg[0] <= numy[NB];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < SCR_STEPS; gi++) begin : g_scr
            logic [DB+1:0] tx, ty;
            logic [DB:0] px, py;
            assign px = {srx_reg[gi][DB-1:0], snx_reg[gi][SDW-1]};
            assign py = {sry_reg[gi][DB-1:0], sny_reg[gi][SDW-1]};
            assign tx = {1'b0, px} - {2'b00, sdx_reg[gi]};
            assign ty = {1'b0, py} - {2'b00, sdy_reg[gi]};
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sv_reg[gi+1] <= 1'b0;
                end else if (en) begin
                    sv_reg[gi+1] <= sv_reg[gi];
                end
                if (en) begin
                    snx_reg[gi+1] <= {snx_reg[gi][SDW-2:0], 1'b0};
                    sny_reg[gi+1] <= {sny_reg[gi][SDW-2:0], 1'b0};
                    srx_reg[gi+1] <= tx[DB+1] ? px : tx[DB:0];
                    sry_reg[gi+1] <= ty[DB+1] ? py : ty[DB:0];
                    sqx_reg[gi+1] <= {sqx_reg[gi][SDW-2:0], ~tx[DB+1]};
                    sqy_reg[gi+1] <= {sqy_reg[gi][SDW-2:0], ~ty[DB+1]};
                    sdx_reg[gi+1] <= sdx_reg[gi];
                    sdy_reg[gi+1] <= sdy_reg[gi];
                    ssx_reg[gi+1] <= ssx_reg[gi];
                    ssy_reg[gi+1] <= ssy_reg[gi];
                end
            end
        end
    endgenerate

    // ---------------- aspect scaling (saturate, multiply, round)
    localparam logic [QW-1:0] XLIM = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] YLIM = {3'b000, {(QW-3){1'b1}}};
    logic [QW-1:0] qx_sat, qy_sat;
    assign qx_sat = (SDW > QW-1 && (sqx_reg[SCR_STEPS] > SDW'(XLIM))) ? XLIM
                    : QW'(sqx_reg[SCR_STEPS]);
    assign qy_sat = (SDW > QW-3 && (sqy_reg[SCR_STEPS] > SDW'(YLIM))) ? YLIM
                    : QW'(sqy_reg[SCR_STEPS]);

    logic a_vld_reg;
    logic [QW+15:0] xprod_reg;
    logic [QW-1:0] ya_reg;
    logic a_sx_reg, a_sy_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= sv_reg[SCR_STEPS];
        end
        if (en) begin
            xprod_reg <= qx_sat * asp_reg;
            ya_reg <= qy_sat;
            a_sx_reg <= ssx_reg[SCR_STEPS];
            a_sy_reg <= ssy_reg[SCR_STEPS];
        end
    end

    logic [QW+15:0] xr;
    logic [QW-1:0] xm;
    assign xr = (xprod_reg + (QW+16)'(2048)) >> 12;
    assign xm = (xr > (QW+16)'(XLIM)) ? XLIM : xr[QW-1:0];

    // ---------------- basis combination: per component products
    logic signed [QW:0] xa, ya;
    assign xa = a_sx_reg ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
    assign ya = a_sy_reg ? -$signed({1'b0, ya_reg}) : $signed({1'b0, ya_reg});

    logic b_vld_reg;
    logic signed [VB-1:0] pf_reg [3], pr_reg [3], pu_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pf_reg[k] <= VB'($signed(fwd_reg[16*k +: 16])) <<< FRAC_BITS;
                pr_reg[k] <= VB'($signed(rgt_reg[16*k +: 16]) * xa);
                pu_reg[k] <= VB'($signed(up_reg[16*k +: 16]) * ya);
            end
        end
    end

    logic c_vld_reg;
    logic [MB-1:0] cmag_reg [3];
    logic [2:0] cneg_reg;
    logic signed [VB-1:0] vsum [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vsum[k] = pf_reg[k] + pr_reg[k] + pu_reg[k];
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= b_vld_reg;
        end
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                cneg_reg[k] <= vsum[k][VB-1];
                cmag_reg[k] <= vsum[k][VB-1] ? MB'(-vsum[k]) : MB'(vsum[k]);
            end
        end
    end

    // ---------------- normalization: one binary shift step per cell
    // Left-align the OR of magnitudes at bit MB-1, then take the top 30 bits.
    logic          n_vld_reg [NORM_STEPS+1];
    logic [MB-1:0] nm_reg [NORM_STEPS+1][3];
    logic [2:0]    nneg_reg [NORM_STEPS+1];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_vld_reg[0] <= 1'b0;
        end else if (en) begin
            n_vld_reg[0] <= c_vld_reg;
        end
        if (en) begin
            nm_reg[0] <= cmag_reg;
            nneg_reg[0] <= cneg_reg;
        end
    end
    generate
        for (gi = 0; gi < NORM_STEPS; gi++) begin : g_norm
            localparam int SH = 1 << (NORM_STEPS - 1 - gi);
            logic [MB-1:0] orv;
            logic top_zero;
            assign orv = nm_reg[gi][0] | nm_reg[gi][1] | nm_reg[gi][2];
            assign top_zero = (SH < MB) ? (orv[MB-1 -: SH] == '0) : 1'b0;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    n_vld_reg[gi+1] <= 1'b0;
                end else if (en) begin
                    n_vld_reg[gi+1] <= n_vld_reg[gi];
                end
                if (en) begin
                    nneg_reg[gi+1] <= nneg_reg[gi];
                    for (int k = 0; k < 3; k++) begin
                        nm_reg[gi+1][k] <= top_zero ? (nm_reg[gi][k] << SH) : nm_reg[gi][k];
                    end
                end
            end
        end
    endgenerate

    // Square-root chain entry
    logic [prd_pkg::NORM_BITS-1:0] na [3];
    logic nzero;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            na[k] = nm_reg[NORM_STEPS][k][MB-1 -: prd_pkg::NORM_BITS];
        end
    end
    assign nzero = (nm_reg[NORM_STEPS][0] | nm_reg[NORM_STEPS][1]
                   | nm_reg[NORM_STEPS][2]) == '0;

    logic s_vld_reg;
    logic [prd_pkg::SUMSQ_BITS-1:0] sq_reg [3];
    logic [prd_pkg::NORM_BITS-1:0] sa_reg [3];
    logic [2:0] sneg_reg;
    logic szero_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_vld_reg <= 1'b0;
        end else if (en) begin
            s_vld_reg <= n_vld_reg[NORM_STEPS];
        end
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= prd_pkg::SUMSQ_BITS'(na[k] * na[k]);
            end
            sa_reg <= na;
            sneg_reg <= nneg_reg[NORM_STEPS];
            szero_reg <= nzero;
        end
    end

    prd_pkg::sqrt_tok_t sq_tok [SQ_STEPS+1];
    always_comb begin
        sq_tok[0].vld = s_vld_reg;
        sq_tok[0].rem = sq_reg[0] + sq_reg[1] + sq_reg[2];
        sq_tok[0].root = '0;
        sq_tok[0].ax = sa_reg[0];
        sq_tok[0].ay = sa_reg[1];
        sq_tok[0].az = sa_reg[2];
        sq_tok[0].neg = sneg_reg;
        sq_tok[0].zero = szero_reg;
    end
    generate
        for (gi = 0; gi < SQ_STEPS; gi++) begin : g_sqrt
            prd_sqrt_cell #(.STEP(gi)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .en(en),
                .tok_in(sq_tok[gi]), .tok_out(sq_tok[gi+1])
            );
        end
    endgenerate

    // ---------------- divider chain: q = (a*2^14 + L/2) / L, 16 quotient bits
    // a < 2^30 and L >= 2^29, so the dividend's high part is below L and q < 2^16.
    // High part starts as remainder; the low 16 dividend bits sit in q and are
    // shifted into the remainder one per cell as quotient bits come in.
    logic [prd_pkg::LEN_BITS-1:0] len;
    logic [prd_pkg::NORM_BITS+15:0] half_len, dvx, dvy, dvz;
    assign len = sq_tok[SQ_STEPS].root[prd_pkg::LEN_BITS-1:0];
    assign half_len = (prd_pkg::NORM_BITS+16)'(len >> 1);
    assign dvx = (prd_pkg::NORM_BITS+16)'({sq_tok[SQ_STEPS].ax, 14'd0}) + half_len;
    assign dvy = (prd_pkg::NORM_BITS+16)'({sq_tok[SQ_STEPS].ay, 14'd0}) + half_len;
    assign dvz = (prd_pkg::NORM_BITS+16)'({sq_tok[SQ_STEPS].az, 14'd0}) + half_len;

    prd_pkg::div_tok_t dv_in;
    always_comb begin
        dv_in.vld = sq_tok[SQ_STEPS].vld;
        dv_in.den = len;
        dv_in.rx = dvx >> 16;
        dv_in.ry = dvy >> 16;
        dv_in.rz = dvz >> 16;
        dv_in.qx = dvx[15:0];
        dv_in.qy = dvy[15:0];
        dv_in.qz = dvz[15:0];
        dv_in.neg = sq_tok[SQ_STEPS].neg;
        dv_in.zero = sq_tok[SQ_STEPS].zero;
    end

    prd_pkg::div_tok_t dv_stage [DV_STEPS+1];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_stage[0].vld <= 1'b0;
        end else if (en) begin
            dv_stage[0] <= dv_in;
        end
    end
    generate
        for (gi = 0; gi < DV_STEPS; gi++) begin : g_div
            prd_pkg::div_tok_t cell_out;
            prd_div_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .en(en),
                .tok_in(dv_stage[gi]), .tok_out(cell_out)
            );
            always_comb begin
                dv_stage[gi+1] = cell_out;
            end
        end
    endgenerate

    // ---------------- output register
    logic signed [15:0] ox_reg, oy_reg, oz_reg;
    prd_pkg::div_tok_t dv_end;
    assign dv_end = dv_stage[DV_STEPS];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_end.vld;
        end
        if (en) begin
            ox_reg <= dv_end.zero ? '0 : (dv_end.neg[0] ? -dv_end.qx : dv_end.qx);
            oy_reg <= dv_end.zero ? '0 : (dv_end.neg[1] ? -dv_end.qy : dv_end.qy);
            oz_reg <= dv_end.zero ? '0 : (dv_end.neg[2] ? -dv_end.qz : dv_end.qz);
        end
    end

    assign m_valid = out_vld_reg;
    assign m_dir_x = ox_reg;
    assign m_dir_y = oy_reg;
    assign m_dir_z = oz_reg;

    // ---------------- assertions
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dir_x))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_dir_x <= 16'sd16384 && m_dir_x >= -16'sd16384))
        else $error("direction out of range");

endmodule

FILE: tb/pixel_ray_direction_core_tb.sv
// Testbench for pixel_ray_direction_core: directed and random pixel requests under several
// camera settings and idle patterns, checked against an in-bench direction predictor.
// Depends on prd_pkg and the pixel_ray_direction_core RTL.
module pixel_ray_direction_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned XSAT = (64'd1 << 47) - 1;
    localparam longint unsigned YSAT = (64'd1 << 45) - 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } dir_t;

    // Scoreboard: camera copy, direction predictor, queue of pending directions
    class ray_scoreboard;
        logic [47:0] fwd, rgt, upv;
        logic [12:0] width, height;
        logic [15:0] aspect;
        dir_t pending_dirs[$];

        function void load_defaults();
            fwd = prd_pkg::FORWARD_RST; rgt = prd_pkg::RIGHT_RST; upv = prd_pkg::UP_RST;
            width = prd_pkg::WIDTH_RST; height = prd_pkg::HEIGHT_RST;
            aspect = prd_pkg::ASPECT_RST;
        endfunction

        function void write_reg(logic [prd_pkg::CFG_IDX_BITS-1:0] idx, logic [47:0] val);
            case (idx)
                prd_pkg::REG_FORWARD: fwd = val;
                prd_pkg::REG_RIGHT:   rgt = val;
                prd_pkg::REG_UP:      upv = val;
                prd_pkg::REG_WIDTH:   width = val[12:0];
                prd_pkg::REG_HEIGHT:  height = val[12:0];
                prd_pkg::REG_ASPECT:  aspect = val[15:0];
                default: ;
            endcase
        endfunction

        static function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : longint'(v);
        endfunction

        // Rounded, saturated screen coordinate, sign taken from the numerator
        static function longint screen(longint num, longint unsigned den,
                                       longint unsigned lim);
            longint unsigned q;
            q = ((mag(num) << 14) + den / 2) / den;
            if (q > lim) q = lim;
            return num < 0 ? -longint'(q) : longint'(q);
        endfunction

        static function longint unsigned isqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function dir_t predict(logic [11:0] col, logic [11:0] row,
                               logic [7:0] sx, logic [7:0] sy);
            longint unsigned w, h, rx, ry, xm, m, sum, len, q;
            longint unsigned a[3];
            logic neg[3];
            longint xs, ys, xa, v;
            logic [15:0] comp[3];
            dir_t d;
            w = (width == 0) ? 1 : width;
            h = (height == 0) ? 1 : height;
            rx = (longint'(col) << 8) + sx;
            ry = (longint'(row) << 8) + sy;
            xs = screen(2 * longint'(rx) - longint'(256 * w), 256 * w, XSAT);
            ys = screen(longint'(256 * h) - 2 * longint'(ry), 256 * h, YSAT);
            xm = (mag(xs) * aspect + 2048) >> 12;
            if (xm > XSAT) xm = XSAT;
            xa = xs < 0 ? -longint'(xm) : longint'(xm);
            m = 0;
            for (int i = 0; i < 3; i++) begin
                v = longint'($signed(fwd[16*i +: 16])) * 16384
                  + longint'($signed(rgt[16*i +: 16])) * xa
                  + longint'($signed(upv[16*i +: 16])) * ys;
                neg[i] = v < 0;
                a[i] = mag(v);
                if (a[i] > m) m = a[i];
            end
            // zero-length vector gives a zero direction
            if (m == 0) return '0;
            while (m >= (64'd1 << 30)) begin
                m = m >> 1;
                for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
            end
            while (m < (64'd1 << 29)) begin
                m = m << 1;
                for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
            end
            sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            len = isqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = ((a[i] << 14) + len / 2) / len;
                comp[i] = neg[i] ? 16'(-q) : 16'(q);
            end
            d.x = comp[0]; d.y = comp[1]; d.z = comp[2];
            return d;
        endfunction

        function void note_request(logic [11:0] col, logic [11:0] row,
                                   logic [7:0] sx, logic [7:0] sy);
            pending_dirs.push_back(predict(col, row, sx, sy));
        endfunction

        // Returns number of bad fields; msg describes the first problem
        function int check_result(dir_t got, output string msg);
            dir_t e;
            int bad;
            bad = 0;
            msg = "";
            if (pending_dirs.size() == 0) begin
                msg = $sformatf("unexpected result %0d %0d %0d", got.x, got.y, got.z);
                return 1;
            end
            e = pending_dirs.pop_front();
            if (got.x !== e.x) bad++;
            if (got.y !== e.y) bad++;
            if (got.z !== e.z) bad++;
            if (bad != 0)
                msg = $sformatf("dir got %0d %0d %0d exp %0d %0d %0d",
                                got.x, got.y, got.z, e.x, e.y, e.z);
            return bad;
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    logic [11:0] s_column, s_row;
    logic [7:0] s_sub_x, s_sub_y;
    logic signed [15:0] m_dir_x, m_dir_y, m_dir_z;
    logic [prd_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [prd_pkg::CFG_DATA_BITS-1:0] cfg_data;

    ray_scoreboard sb;
    int error_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    pixel_ray_direction_core dut (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Monitor: note accepted requests, check accepted results
    always @(posedge aclk) begin
        string msg;
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_column, s_row, s_sub_x, s_sub_y);
            requests_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (sb.check_result({m_dir_x, m_dir_y, m_dir_z}, msg) != 0)
                report_mismatch(msg);
        end
    end

    // Receiver: long hold-off when requested, else random stalls
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 1'b0;
            hold_cycles--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("pixel_ray_direction_core verification failed");
            $finish;
        end
    end

    task automatic send_pixel(logic [11:0] col, logic [11:0] row,
                              logic [7:0] sx, logic [7:0] sy);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_column = col; s_row = row; s_sub_x = sx; s_sub_y = sy;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending_dirs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [prd_pkg::CFG_IDX_BITS-1:0] idx, logic [47:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_camera(logic [47:0] f, logic [47:0] r, logic [47:0] u,
                              logic [12:0] w, logic [12:0] h, logic [15:0] asp);
        wait_idle();
        write_reg(prd_pkg::REG_FORWARD, f);
        write_reg(prd_pkg::REG_RIGHT, r);
        write_reg(prd_pkg::REG_UP, u);
        write_reg(prd_pkg::REG_WIDTH, {35'd0, w});
        write_reg(prd_pkg::REG_HEIGHT, {35'd0, h});
        write_reg(prd_pkg::REG_ASPECT, {32'd0, asp});
    endtask

    function automatic logic [47:0] rand_vec();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // Mostly pixels inside the image, some anywhere in the coordinate range
    task automatic random_pixels(int count);
        int w, h;
        for (int i = 0; i < count; i++) begin
            w = (sb.width == 0) ? 1 : ((sb.width > 4096) ? 4096 : sb.width);
            h = (sb.height == 0) ? 1 : ((sb.height > 4096) ? 4096 : sb.height);
            if ($urandom_range(99) < 75)
                send_pixel(12'($urandom_range(w - 1)), 12'($urandom_range(h - 1)),
                           8'($urandom), 8'($urandom));
            else
                send_pixel(12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.load_defaults();
        aresetn = 1'b0;
        s_valid = 1'b0; s_column = '0; s_row = '0; s_sub_x = '0; s_sub_y = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed at reset camera: corners, center, field extremes, outside image
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0);
        send_pixel(12'd639, 12'd479, 8'd255, 8'd255);
        send_pixel(12'd320, 12'd240, 8'd0, 8'd0);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255);
        send_pixel(12'd4095, 12'd0, 8'd0, 8'd255);
        send_pixel(12'd0, 12'd4095, 8'd255, 8'd0);
        send_pixel(12'd320, 12'd0, 8'd128, 8'd128);

        // Zero forward vector: center pixel gives zero-length vector
        set_camera(48'd0, prd_pkg::RIGHT_RST, prd_pkg::UP_RST, 13'd640, 13'd480,
                   prd_pkg::ASPECT_RST);
        send_pixel(12'd320, 12'd240, 8'd0, 8'd0);
        send_pixel(12'd321, 12'd240, 8'd0, 8'd0);
        set_camera(48'd0, 48'd0, 48'd0, 13'd640, 13'd480, prd_pkg::ASPECT_RST);
        send_pixel(12'd17, 12'd400, 8'd9, 8'd200);
        // Unknown register indexes must be ignored
        wait_idle();
        write_reg(3'd6, 48'hFFFF_FFFF_FFFF);
        write_reg(3'd7, 48'h1234_5678_9ABC);
        send_pixel(12'd100, 12'd100, 8'd1, 8'd1);

        // Zero image size, max aspect
        set_camera(prd_pkg::FORWARD_RST, prd_pkg::RIGHT_RST, prd_pkg::UP_RST,
                   13'd0, 13'd0, 16'hFFFF);
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255);
        send_pixel(12'd0, 12'd0, 8'd128, 8'd128);
        // Extreme components
        set_camera(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_8000,
                   13'd1, 13'd8191, 16'd0);
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255);
        send_pixel(12'd2048, 12'd100, 8'd64, 8'd32);

        // No idling, random camera, then the reset camera
        set_camera(rand_vec(), rand_vec(), rand_vec(), 13'($urandom_range(1, 4096)),
                   13'($urandom_range(1, 4096)), 16'($urandom));
        random_pixels(60);
        set_camera(prd_pkg::FORWARD_RST, prd_pkg::RIGHT_RST, prd_pkg::UP_RST,
                   13'd640, 13'd480, prd_pkg::ASPECT_RST);
        random_pixels(60);

        // Sender mostly idle, zero image size and max aspect
        send_idle_pct = 82;
        set_camera(rand_vec(), rand_vec(), rand_vec(), 13'd0, 13'd0, 16'hFFFF);
        random_pixels(120);

        // Receiver mostly stalled, with a long hold-off while input keeps coming
        send_idle_pct = 0;
        recv_stall_pct = 82;
        set_camera(rand_vec(), rand_vec(), rand_vec(), 13'd8191, 13'd4096, 16'd0);
        hold_cycles = 400;
        random_pixels(120);

        // Both sides idle, extreme vectors, wide ranges
        send_idle_pct = 31;
        recv_stall_pct = 31;
        set_camera(48'h7FFF_8000_7FFF, rand_vec(), 48'h8000_8000_8000,
                   13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)),
                   16'($urandom));
        random_pixels(120);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_idle();

        $display("covered %0d pixel requests and %0d directions over several cameras",
                 requests_sent, results_seen);
        $display("idle patterns: none, sender 82%%, receiver 82%% with hold-off, both 31%%");
        if (error_count == 0 && sb.pending_dirs.size() == 0) begin
            $display("pixel_ray_direction_core verification clean");
        end else begin
            if (sb.pending_dirs.size() != 0)
                report_mismatch($sformatf("%0d directions never arrived",
                                          sb.pending_dirs.size()));
            $display("pixel_ray_direction_core verification failed");
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/prd_pkg.sv
hdl/prd_sqrt_cell.sv
hdl/prd_div_cell.sv
hdl/pixel_ray_direction_core.sv
tb/pixel_ray_direction_core_tb.sv
